/* rtl/ist_pkg.sv */
// Shared types and constants for the INI span tokenizer.
`timescale 1ns / 1ps

package ist_pkg;

    // Width of the offsets that leave the block, fixed by the result item.
    localparam int SPAN_BITS = 16;

    // Default width of the running byte offset.
    localparam int DEFAULT_OFFSET_BITS = 16;

    // Depth of the queue between the parser and the span emitter.
    localparam int DEFAULT_JOB_DEPTH = 4;

    // Characters that steer the parser.
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Span kinds as they appear on the output.
    localparam logic [1:0] KIND_SECTION = 2'd0;
    localparam logic [1:0] KIND_KEY     = 2'd1;
    localparam logic [1:0] KIND_VALUE   = 2'd2;

    typedef enum logic [2:0] {
        MODE_SECT     = 3'd0,
        MODE_END_SECT = 3'd1,
        MODE_END_LINE = 3'd2,
        MODE_KEY      = 3'd3,
        MODE_END_KEY  = 3'd4,
        MODE_VALUE    = 3'd5,
        MODE_PENDING  = 3'd6
    } parse_mode_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           span_kind;
        logic [SPAN_BITS-1:0] span_first;
        logic [SPAN_BITS-1:0] span_final;
        logic                 run_last;
    } out_item_t;

    // One finished key/value pair, with the section span it may need to announce.
    typedef struct packed {
        logic                 need_section;
        logic [SPAN_BITS-1:0] section_first;
        logic [SPAN_BITS-1:0] section_final;
        logic [SPAN_BITS-1:0] key_first;
        logic [SPAN_BITS-1:0] key_final;
        logic [SPAN_BITS-1:0] value_first;
        logic [SPAN_BITS-1:0] value_final;
    } pair_job_t;

endpackage

/* rtl/ist_front.sv */
// Byte parser: runs the tokenizer state machine and posts finished pairs.
`timescale 1ns / 1ps

module ist_front #(
    parameter int OFFSET_BITS = ist_pkg::DEFAULT_OFFSET_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ist_pkg::in_item_t  in_item,
    output logic               job_push,
    output ist_pkg::pair_job_t job_item,
    input  logic               job_full
);
    import ist_pkg::*;

    localparam int WIDE_BITS = (OFFSET_BITS > SPAN_BITS) ? OFFSET_BITS : SPAN_BITS;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);

    parse_mode_t             mode_reg, mode_next;
    parse_mode_t             resume_reg, resume_next;
    logic [OFFSET_BITS-1:0]  pos_reg, pos_next;
    logic [OFFSET_BITS-1:0]  sec_first_reg, sec_first_next;
    logic [OFFSET_BITS-1:0]  sec_final_reg, sec_final_next;
    logic [OFFSET_BITS-1:0]  key_first_reg, key_first_next;
    logic [OFFSET_BITS-1:0]  key_final_reg, key_final_next;
    logic [OFFSET_BITS-1:0]  val_first_reg, val_first_next;
    logic                    announced_reg, announced_next;

    logic                    accept;
    logic                    push_raw;
    logic                    need_section;
    logic [OFFSET_BITS-1:0]  val_final;
    logic [OFFSET_BITS-1:0]  pos_inc;
    logic [OFFSET_BITS-1:0]  pos_dec;
    logic [7:0]              b;
    logic                    eol;
    logic                    blank;

    function automatic logic [OFFSET_BITS-1:0] off_inc(input logic [OFFSET_BITS-1:0] v);
        return (v == OFF_MAX) ? OFF_MAX : v + OFF_ONE;
    endfunction

    function automatic logic [SPAN_BITS-1:0] to_span(input logic [OFFSET_BITS-1:0] v);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        return w[SPAN_BITS-1:0];
    endfunction

    assign in_ready = !job_full;
    assign accept   = in_valid && in_ready;
    assign b        = in_item.text_byte;
    assign eol      = b inside {CH_LF, CH_CR};
    assign blank    = b inside {CH_SPACE, CH_TAB};
    assign pos_inc  = off_inc(pos_reg);
    assign pos_dec  = pos_reg - OFF_ONE;

    always_comb
    begin
        mode_next      = mode_reg;
        resume_next    = resume_reg;
        sec_first_next = sec_first_reg;
        sec_final_next = sec_final_reg;
        key_first_next = key_first_reg;
        key_final_next = key_final_reg;
        val_first_next = val_first_reg;
        announced_next = announced_reg;
        push_raw       = 1'b0;
        need_section   = !announced_reg;
        val_final      = pos_dec;

        case (mode_reg)
            MODE_SECT:
            begin
                if (b == CH_LBRACK) begin
                    sec_first_next = pos_inc;
                    mode_next      = MODE_END_SECT;
                end else if (b == CH_HASH) begin
                    mode_next = MODE_END_LINE;
                end
            end
            MODE_END_SECT:
            begin
                if (b == CH_RBRACK) begin
                    sec_final_next = pos_dec;
                    mode_next      = MODE_END_LINE;
                    resume_next    = MODE_KEY;
                    announced_next = 1'b0;
                end else if (b == CH_HASH || b == CH_SPACE) begin
                    mode_next   = MODE_END_LINE;
                    resume_next = MODE_SECT;
                end else if (eol) begin
                    mode_next = MODE_SECT;
                end
            end
            MODE_END_LINE:
            begin
                if (eol) begin
                    if (resume_reg == MODE_PENDING) begin
                        push_raw       = 1'b1;
                        announced_next = 1'b1;
                        mode_next      = MODE_KEY;
                    end else begin
                        mode_next = resume_reg;
                    end
                end
            end
            MODE_KEY:
            begin
                if (eol || blank) begin
                    mode_next = MODE_KEY;
                end else if (b == CH_HASH) begin
                    resume_next = MODE_KEY;
                    mode_next   = MODE_END_LINE;
                end else if (b == CH_LBRACK) begin
                    sec_first_next = pos_inc;
                    mode_next      = MODE_END_SECT;
                end else begin
                    key_first_next = pos_reg;
                    mode_next      = MODE_END_KEY;
                end
            end
            MODE_END_KEY:
            begin
                if (eol) begin
                    resume_next = MODE_SECT;
                    mode_next   = MODE_END_LINE;
                end else if (blank) begin
                    key_final_next = pos_dec;
                    mode_next      = MODE_VALUE;
                end else if (b == CH_EQUAL) begin
                    key_final_next = pos_dec;
                    val_first_next = pos_inc;
                    resume_next    = MODE_PENDING;
                    mode_next      = MODE_END_LINE;
                end
            end
            MODE_VALUE:
            begin
                if (eol) begin
                    mode_next = MODE_KEY;
                end else if (b == CH_EQUAL) begin
                    val_first_next = pos_inc;
                    resume_next    = MODE_PENDING;
                    mode_next      = MODE_END_LINE;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        pos_next = pos_inc;

        // A pair is built from the span registers as they stand after this byte.
        job_item.section_first = to_span(sec_first_next);
        job_item.section_final = to_span(sec_final_next);
        job_item.key_first     = to_span(key_first_next);
        job_item.key_final     = to_span(key_final_next);
        job_item.value_first   = to_span(val_first_next);

        // The final byte flushes a pair still waiting for its line end,
        // then everything returns to its reset value.
        if (in_item.stream_end) begin
            if (mode_next == MODE_END_LINE && resume_next == MODE_PENDING) begin
                push_raw     = 1'b1;
                need_section = !announced_next;
                val_final    = pos_inc - OFF_ONE;
            end
            mode_next      = MODE_SECT;
            resume_next    = MODE_SECT;
            pos_next       = '0;
            sec_first_next = '0;
            sec_final_next = '0;
            key_first_next = '0;
            key_final_next = '0;
            val_first_next = '0;
            announced_next = 1'b0;
        end

        job_item.need_section = need_section;
        job_item.value_final  = to_span(val_final);
    end

    assign job_push = accept && push_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      <= MODE_SECT;
            resume_reg    <= MODE_SECT;
            pos_reg       <= '0;
            sec_first_reg <= '0;
            sec_final_reg <= '0;
            key_first_reg <= '0;
            key_final_reg <= '0;
            val_first_reg <= '0;
            announced_reg <= 1'b0;
        end else if (accept) begin
            mode_reg      <= mode_next;
            resume_reg    <= resume_next;
            pos_reg       <= pos_next;
            sec_first_reg <= sec_first_next;
            sec_final_reg <= sec_final_next;
            key_first_reg <= key_first_next;
            key_final_reg <= key_final_next;
            val_first_reg <= val_first_next;
            announced_reg <= announced_next;
        end
    end

endmodule

/* rtl/ist_job_fifo.sv */
// Short queue of finished pairs between the parser and the span emitter.
`timescale 1ns / 1ps

module ist_job_fifo #(
    parameter int DEPTH = ist_pkg::DEFAULT_JOB_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ist_pkg::pair_job_t push_item,
    output logic               full,
    input  logic               pop,
    output ist_pkg::pair_job_t head_item,
    output logic               head_valid
);
    import ist_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

    pair_job_t             slots_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full       = (count_reg == FULL_COUNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_BITS'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/ist_back.sv */
// Span emitter: expands each queued pair into key and value items, with a section item first when needed.
`timescale 1ns / 1ps

module ist_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ist_pkg::pair_job_t head_item,
    input  logic               head_valid,
    output logic               head_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output ist_pkg::out_item_t out_item
);
    import ist_pkg::*;

    logic        out_valid_reg, out_valid_next;
    out_item_t   out_item_reg, out_item_next;
    logic        started_reg, started_next;
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  cur_kind;
    logic        load;

    // The first span of a pair is the section only when it still needs announcing.
    assign cur_kind = started_reg ? phase_reg
                    : (head_item.need_section ? KIND_SECTION : KIND_KEY);
    assign load     = head_valid && (!out_valid_reg || out_ready);
    assign head_pop = load && (cur_kind == KIND_VALUE);

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        started_next   = started_reg;
        phase_next     = phase_reg;
        if (load) begin
            out_valid_next          = 1'b1;
            out_item_next.span_kind = cur_kind;
            out_item_next.run_last  = 1'b0;
            case (cur_kind)
                KIND_SECTION:
                begin
                    out_item_next.span_first = head_item.section_first;
                    out_item_next.span_final = head_item.section_final;
                    started_next             = 1'b1;
                    phase_next               = KIND_KEY;
                end
                KIND_KEY:
                begin
                    out_item_next.span_first = head_item.key_first;
                    out_item_next.span_final = head_item.key_final;
                    started_next             = 1'b1;
                    phase_next               = KIND_VALUE;
                end
                default:
                begin
                    out_item_next.span_first = head_item.value_first;
                    out_item_next.span_final = head_item.value_final;
                    out_item_next.run_last   = 1'b1;
                    started_next             = 1'b0;
                    phase_next               = KIND_SECTION;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            phase_reg     <= KIND_SECTION;
        end else begin
            out_valid_reg <= out_valid_next;
            started_reg   <= started_next;
            phase_reg     <= phase_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* rtl/ini_span_tokenizer_top.sv */
// Top level of the INI span tokenizer: parser, pair queue and span emitter.
`timescale 1ns / 1ps

// The block takes one text byte per cycle and reports section, key and value
// spans as byte offsets. The parser handles each byte in the cycle it is
// accepted, so bytes flow at one per cycle; a finished key/value pair goes into
// a queue of JOB_DEPTH pairs and the emitter sends its two or three spans at
// one per cycle from a registered output while out_ready is high. Input stalls
// only when that queue is full, which happens when pairs arrive faster than
// the emitter can send their spans or the output is held off. The byte offset
// counter is OFFSET_BITS wide and saturates; offsets are reported as their low
// 16 bits. All parser state returns to its reset values after a byte marked
// stream_end.
module ini_span_tokenizer_top #(
    parameter int OFFSET_BITS = ist_pkg::DEFAULT_OFFSET_BITS,
    parameter int JOB_DEPTH   = ist_pkg::DEFAULT_JOB_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ist_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output ist_pkg::out_item_t out_item
);
    import ist_pkg::*;

    logic      job_push;
    pair_job_t job_item;
    logic      job_full;
    logic      job_pop;
    pair_job_t head_item;
    logic      head_valid;

    ist_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .job_push (job_push),
        .job_item (job_item),
        .job_full (job_full)
    );

    ist_job_fifo #(
        .DEPTH(JOB_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_item  (job_item),
        .full       (job_full),
        .pop        (job_pop),
        .head_item  (head_item),
        .head_valid (head_valid)
    );

    ist_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_item  (head_item),
        .head_valid (head_valid),
        .head_pop   (job_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule
